// ===== rtl/tpz_pkg.sv =====
// Shared types, constants and tables of the torus point z-buffer shader.
// Holds the command and result records, register indexes and the trig tables.
// No dependencies.
package tpz_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;
  localparam int ANGLE_STEPS   = 1024;
  localparam int STORE_DEPTH   = 16384;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int TRIG_W        = $clog2(ANGLE_STEPS);
  localparam int CHAR_W        = 8;

  // Q8.8 screen center offsets and the torus major radius.
  localparam int HALF_W_Q8  = (SCREEN_WIDTH / 2) * 256;
  localparam int HALF_H_Q8  = (SCREEN_HEIGHT / 2) * 256;
  localparam int RC_BASE    = 42 * 256;
  localparam int SQRT2_Q14  = 23170;

  localparam logic signed [15:0] DEPTH_NEG_INF = 16'sh8000;

  // Q28 angle constants.
  localparam longint PI_Q28      = 64'd843314857;
  localparam longint HALF_PI_Q28 = 64'd421657428;
  localparam longint TWO_PI_Q28  = 64'd1686629714;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_B64_ZERO = 8'h41;

  // Configuration register indexes.
  localparam logic [1:0] REG_COLOR_MODE = 2'd0;
  localparam logic [1:0] REG_ROT_PHI    = 2'd1;
  localparam logic [1:0] REG_ROT_THETA  = 2'd2;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_SAMPLE = 2'd1,
    FN_READ   = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [TRIG_W-1:0] u_idx;
    logic [TRIG_W-1:0] v_idx;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic              visible;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] c_first;
    logic [CHAR_W-1:0] c_second;
    logic [CHAR_W-1:0] c_third;
    logic [CHAR_W-1:0] c_fourth;
  } res_t;

  typedef struct packed {
    logic       color_mode;
    logic [9:0] rotation_phi;
    logic [9:0] rotation_theta;
  } cfg_t;

  typedef logic signed [15:0] trig_tab_t [ANGLE_STEPS];

  // Sine of a Q28 angle in [0, 2.5 pi), Q14 result, by a seven-term series.
  function automatic logic signed [15:0] sin_q28(input longint a_in);
    longint a;
    longint x2;
    longint term;
    longint sum;
    logic   neg;
    a   = a_in;
    neg = 1'b0;
    if (a >= TWO_PI_Q28) a = a - TWO_PI_Q28;
    if (a >= PI_Q28) begin
      a   = a - PI_Q28;
      neg = 1'b1;
    end
    if (a > HALF_PI_Q28) a = PI_Q28 - a;
    if (a < 0) a = 0;
    x2   = (a * a) >>> 28;
    term = a;
    sum  = a;
    term = ((term * x2) >>> 28) / 6;   sum = sum - term;
    term = ((term * x2) >>> 28) / 20;  sum = sum + term;
    term = ((term * x2) >>> 28) / 42;  sum = sum - term;
    term = ((term * x2) >>> 28) / 72;  sum = sum + term;
    term = ((term * x2) >>> 28) / 110; sum = sum - term;
    term = ((term * x2) >>> 28) / 156; sum = sum + term;
    if (sum < 0) sum = 0;
    sum = (sum + 8192) >>> 14;
    if (sum > 16384) sum = 16384;
    return neg ? 16'(-sum) : 16'(sum);
  endfunction

  function automatic trig_tab_t build_trig(input logic cos_sel);
    trig_tab_t tab;
    longint    ang;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      ang = (longint'(i) * TWO_PI_Q28) / ANGLE_STEPS;
      if (cos_sel) ang = ang + HALF_PI_Q28;
      tab[i] = sin_q28(ang);
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig(1'b0);
  localparam trig_tab_t COS_TAB = build_trig(1'b1);

  function automatic logic [CHAR_W-1:0] ramp_char(input logic [3:0] lv);
    logic [CHAR_W-1:0] c;
    case (lv)
      4'd0:    c = " ";
      4'd1:    c = ".";
      4'd2:    c = ":";
      4'd3:    c = "-";
      4'd4:    c = "=";
      4'd5:    c = "+";
      4'd6:    c = "*";
      4'd7:    c = "#";
      4'd8:    c = "%";
      4'd9:    c = "@";
      default: c = " ";
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    if (idx < 6'd26)      c = 8'h41 + 8'(idx);
    else if (idx < 6'd52) c = 8'h61 + 8'(idx - 6'd26);
    else if (idx < 6'd62) c = 8'h30 + 8'(idx - 6'd52);
    else if (idx == 6'd62) c = "+";
    else                  c = "/";
    return c;
  endfunction

endpackage

// ===== rtl/tpz_front.sv =====
// Front end of the torus point z-buffer shader: takes commands, decodes them
// and holds them in a two-entry command queue for the back end.
// Depends on tpz_pkg.
module tpz_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [1:0]                func_i,
  input  logic [9:0]                u_step_i,
  input  logic [9:0]                v_step_i,
  input  logic [13:0]               pixel_address_i,
  output logic                      cmd_valid_o,
  output tpz_pkg::cmd_t             cmd_o,
  input  logic                      cmd_pop_i
);
  import tpz_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_in;
  logic       do_push, do_pop;

  // Angles in units of pi/256 become table steps, rounded and wrapped.
  always_comb begin
    cmd_in.func  = func_e'(func_i);
    cmd_in.u_idx = TRIG_W'((32'(u_step_i) * ANGLE_STEPS + 256) >> 9);
    cmd_in.v_idx = TRIG_W'((32'(v_step_i) * ANGLE_STEPS + 256) >> 9);
    cmd_in.addr  = ADDR_W'(pixel_address_i);
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= cmd_in;
  end

endmodule

// ===== rtl/tpz_outq.sv =====
// Two-entry result queue that separates the back end from the receiver.
// Depends on tpz_pkg.
module tpz_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpz_pkg::res_t res_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output tpz_pkg::res_t res_o
);
  import tpz_pkg::*;

  res_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= res_i;
  end

endmodule

// ===== rtl/tpz_back.sv =====
// Back end of the torus point z-buffer shader: trig table lookup, a shared
// multiply-accumulate sequencer, projection, depth test and the two stores.
// Depends on tpz_pkg.
module tpz_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  tpz_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  tpz_pkg::cfg_t cfg_i,
  input  logic          res_full_i,
  output logic          res_push_o,
  output tpz_pkg::res_t res_o
);
  import tpz_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_RDWAIT = 6'b000010,
    ST_LOOK   = 6'b000100,
    ST_MAC    = 6'b001000,
    ST_PROJ   = 6'b010000,
    ST_TEST   = 6'b100000
  } state_e;

  typedef enum logic [1:0] {SH_NONE, SH_6, SH_14, SH_28} shift_e;

  typedef enum logic [3:0] {
    D_NONE, D_X0, D_Y0, D_NX0, D_NY0, D_PST, D_PCT, D_CST, D_CCT,
    D_X, D_Y, D_Z, D_NX, D_NY, D_NZ, D_L2
  } dest_e;

  typedef struct packed {
    logic   valid;
    logic   first;
    logic   last;
    logic   neg;
    logic   up14;
    shift_e shift;
    dest_e  dest;
  } mac_ctl_t;

  localparam logic [2:0] LOOK_LAST = 3'd4;
  localparam logic [4:0] MAC_LAST  = 5'd26;

  // Round to nearest with halves away from zero.
  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v,
                                                   input shift_e sh);
    logic [47:0] m;
    logic [47:0] r;
    m = v[47] ? 48'(-v) : 48'(v);
    case (sh)
      SH_6:    r = (m + 48'd32) >> 6;
      SH_14:   r = (m + 48'd8192) >> 14;
      SH_28:   r = (m + 48'd134217728) >> 28;
      default: r = m;
    endcase
    return v[47] ? -$signed(r) : $signed(r);
  endfunction

  state_e            state_q, state_d;
  logic [2:0]        lk_cnt_q, lk_cnt_d;
  logic [4:0]        step_q, step_d;
  mac_ctl_t          mac_ctl, mac_ctl_q;

  logic [TRIG_W-1:0] iu_q, iv_q, rom_idx;
  logic [ADDR_W-1:0] addr_q;
  logic signed [15:0] sin_rd_q, cos_rd_q;
  logic signed [15:0] cu_q, su_q, cv_q, sv_q, cp_q, sp_q, ct_q, st_q;
  logic signed [15:0] x0_q, y0_q, nx0_q, ny0_q;
  logic signed [29:0] pst_q, pct_q, cst_q, cct_q;
  logic signed [17:0] x_q, y_q, z_q, nx_q, ny_q, nz_q, l2_q;
  logic signed [15:0] rc, z0;
  logic signed [15:0] mac_a;
  logic signed [29:0] mac_b;
  logic signed [45:0] prod_q;
  logic signed [47:0] acc_q, term, acc_sum, mac_res;

  // Projection and depth test.
  logic signed [19:0] sx, sy;
  logic [19:0]        mag_x, mag_y;
  logic [11:0]        qx, qy;
  logic               inb_c, inb_q;
  logic [11:0]        col, row;
  logic [ADDR_W-1:0]  waddr_c, waddr_q;
  logic signed [15:0] dep_rd_q;
  logic               pass;

  // Shading.
  logic signed [21:0] l1;
  logic [21:0]        l1c;
  logic [16:0]        l2c;
  logic [29:0]        red_w, blue_w, lv_w;
  logic [7:0]         r8, b8;
  logic [3:0]         lv;
  logic [31:0]        shade_px;

  // Stores and their ports.
  logic signed [15:0] dep_mem [STORE_DEPTH];
  logic [31:0]        pix_mem [STORE_DEPTH];
  logic               dep_we, pix_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic signed [15:0] dep_wd;
  logic [31:0]        pix_wd, pix_rd_q, clear_px;
  logic [CHAR_W-1:0]  clear_ch;
  res_t               res_d;

  // Torus tube radius terms, from the stored minor-angle cosine and sine.
  assign rc = 16'(48'(RC_BASE) + rnd_shift(48'(cv_q) * 48'sd18, SH_6));
  assign z0 = 16'(rnd_shift(48'(sv_q) * 48'sd18, SH_6));

  always_comb begin
    case (lk_cnt_q)
      3'd0:    rom_idx = iu_q;
      3'd1:    rom_idx = iv_q;
      3'd2:    rom_idx = TRIG_W'((32'(cfg_i.rotation_phi) * ANGLE_STEPS + 512) >> 10);
      3'd3:    rom_idx = TRIG_W'((32'(cfg_i.rotation_theta) * ANGLE_STEPS + 512) >> 10);
      default: rom_idx = iu_q;
    endcase
  end

  // Multiply-accumulate program: point, normal, their rotations, then light.
  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_ctl = '{valid: 1'b0, first: 1'b1, last: 1'b1, neg: 1'b0, up14: 1'b0,
                shift: SH_14, dest: D_NONE};
    if (state_q == ST_MAC) begin
      mac_ctl.valid = 1'b1;
      case (step_q)
        5'd0:  begin mac_a = rc;    mac_b = 30'(cu_q); mac_ctl.dest = D_X0; end
        5'd1:  begin mac_a = rc;    mac_b = 30'(su_q); mac_ctl.dest = D_Y0; end
        5'd2:  begin mac_a = cv_q;  mac_b = 30'(cu_q); mac_ctl.dest = D_NX0; end
        5'd3:  begin mac_a = cv_q;  mac_b = 30'(su_q); mac_ctl.dest = D_NY0; end
        5'd4:  begin
          mac_a = sp_q; mac_b = 30'(st_q); mac_ctl.shift = SH_NONE; mac_ctl.dest = D_PST;
        end
        5'd5:  begin
          mac_a = sp_q; mac_b = 30'(ct_q); mac_ctl.shift = SH_NONE; mac_ctl.dest = D_PCT;
        end
        5'd6:  begin
          mac_a = cp_q; mac_b = 30'(st_q); mac_ctl.shift = SH_NONE; mac_ctl.dest = D_CST;
        end
        5'd7:  begin
          mac_a = cp_q; mac_b = 30'(ct_q); mac_ctl.shift = SH_NONE; mac_ctl.dest = D_CCT;
        end
        5'd8:  begin mac_a = x0_q; mac_b = 30'(ct_q); mac_ctl.last = 1'b0; end
        5'd9:  begin
          mac_a = z0; mac_b = 30'(st_q); mac_ctl.first = 1'b0; mac_ctl.dest = D_X;
        end
        5'd10: begin mac_a = x0_q; mac_b = pst_q; mac_ctl.last = 1'b0; end
        5'd11: begin
          mac_a = y0_q; mac_b = 30'(cp_q);
          mac_ctl.first = 1'b0; mac_ctl.last = 1'b0; mac_ctl.up14 = 1'b1;
        end
        5'd12: begin
          mac_a = z0; mac_b = pct_q; mac_ctl.first = 1'b0; mac_ctl.neg = 1'b1;
          mac_ctl.shift = SH_28; mac_ctl.dest = D_Y;
        end
        5'd13: begin mac_a = x0_q; mac_b = cst_q; mac_ctl.last = 1'b0; mac_ctl.neg = 1'b1; end
        5'd14: begin
          mac_a = y0_q; mac_b = 30'(sp_q);
          mac_ctl.first = 1'b0; mac_ctl.last = 1'b0; mac_ctl.up14 = 1'b1;
        end
        5'd15: begin
          mac_a = z0; mac_b = cct_q; mac_ctl.first = 1'b0;
          mac_ctl.shift = SH_28; mac_ctl.dest = D_Z;
        end
        5'd16: begin mac_a = nx0_q; mac_b = 30'(ct_q); mac_ctl.last = 1'b0; end
        5'd17: begin
          mac_a = sv_q; mac_b = 30'(st_q); mac_ctl.first = 1'b0; mac_ctl.dest = D_NX;
        end
        5'd18: begin mac_a = nx0_q; mac_b = pst_q; mac_ctl.last = 1'b0; end
        5'd19: begin
          mac_a = ny0_q; mac_b = 30'(cp_q);
          mac_ctl.first = 1'b0; mac_ctl.last = 1'b0; mac_ctl.up14 = 1'b1;
        end
        5'd20: begin
          mac_a = sv_q; mac_b = pct_q; mac_ctl.first = 1'b0; mac_ctl.neg = 1'b1;
          mac_ctl.shift = SH_28; mac_ctl.dest = D_NY;
        end
        5'd21: begin
          mac_a = nx0_q; mac_b = cst_q; mac_ctl.last = 1'b0; mac_ctl.neg = 1'b1;
        end
        5'd22: begin
          mac_a = ny0_q; mac_b = 30'(sp_q);
          mac_ctl.first = 1'b0; mac_ctl.last = 1'b0; mac_ctl.up14 = 1'b1;
        end
        5'd23: begin
          mac_a = sv_q; mac_b = cct_q; mac_ctl.first = 1'b0;
          mac_ctl.shift = SH_28; mac_ctl.dest = D_NZ;
        end
        // Step 24 waits for the normal's z to land before the light term.
        5'd25: begin
          mac_a = 16'(SQRT2_Q14); mac_b = 30'(ny_q) + 30'(nz_q); mac_ctl.dest = D_L2;
        end
        default: mac_ctl.valid = 1'b0;
      endcase
    end
  end

  always_comb begin
    term    = mac_ctl_q.up14 ? (48'(prod_q) <<< 14) : 48'(prod_q);
    acc_sum = (mac_ctl_q.first ? 48'sd0 : acc_q) + (mac_ctl_q.neg ? -term : term);
    mac_res = rnd_shift(acc_sum, mac_ctl_q.shift);
  end

  // Projection with truncation toward zero; a small negative coordinate
  // truncates to column or row zero and stays on screen.
  always_comb begin
    sx    = (cfg_i.color_mode ? 20'(x_q) : (20'(x_q) <<< 1)) + 20'(HALF_W_Q8);
    sy    = 20'(y_q) + 20'(HALF_H_Q8);
    mag_x = sx[19] ? 20'(-sx) : 20'(sx);
    mag_y = sy[19] ? 20'(-sy) : 20'(sy);
    qx    = 12'(mag_x >> 8);
    qy    = 12'(mag_y >> 8);
    col   = sx[19] ? 12'd0 : qx;
    row   = sy[19] ? 12'd0 : qy;
    inb_c = (sx[19] ? (qx == 12'd0) : (32'(qx) < SCREEN_WIDTH)) &&
            (sy[19] ? (qy == 12'd0) : (32'(qy) < SCREEN_HEIGHT));
    waddr_c = ADDR_W'(32'(row) * SCREEN_WIDTH + 32'(col));
  end

  assign pass = inb_q && (z_q >= 18'(dep_rd_q));

  always_comb begin
    l1     = (22'(nx_q) + 22'(ny_q) + 22'(nz_q)) <<< 1;
    l1c    = l1[21] ? 22'd0 : 22'(l1);
    l2c    = l2_q[17] ? 17'd0 : 17'(l2_q);
    red_w  = (30'(l1c) << 8) - 30'(l1c);
    blue_w = (30'(l2c) << 8) - 30'(l2c);
    lv_w   = (30'(l2c) << 3) + (30'(l2c) << 1);
    r8     = (red_w[29:14] > 16'd255) ? 8'd255 : red_w[21:14];
    b8     = (blue_w[29:14] > 16'd255) ? 8'd255 : blue_w[21:14];
    lv     = (lv_w[29:14] > 16'd9) ? 4'd9 : lv_w[17:14];
    if (cfg_i.color_mode) begin
      shade_px = {b64_char(b8[5:0]), b64_char({4'd0, b8[7:6]}),
                  b64_char({r8[1:0], 4'd0}), b64_char(r8[7:2])};
    end else begin
      shade_px = {CH_SPACE, CH_SPACE, CH_SPACE, ramp_char(lv)};
    end
  end

  assign clear_ch = cfg_i.color_mode ? CH_B64_ZERO : CH_SPACE;
  assign clear_px = {clear_ch, clear_ch, clear_ch, clear_ch};

  always_comb begin
    state_d   = state_q;
    lk_cnt_d  = lk_cnt_q;
    step_d    = step_q;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_d     = '0;
    dep_we    = 1'b0;
    pix_we    = 1'b0;
    wr_addr   = cmd_i.addr;
    dep_wd    = DEPTH_NEG_INF;
    pix_wd    = clear_px;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.func)
            FN_CLEAR: begin
              dep_we     = 1'b1;
              pix_we     = 1'b1;
              res_push_o = 1'b1;
              res_d      = '{1'b0, cmd_i.addr, clear_ch, clear_ch, clear_ch, clear_ch};
            end
            FN_READ:   state_d = ST_RDWAIT;
            FN_SAMPLE: begin
              state_d  = ST_LOOK;
              lk_cnt_d = 3'd0;
            end
            default:   res_push_o = 1'b1;
          endcase
        end
      end
      ST_RDWAIT: begin
        res_push_o = 1'b1;
        res_d      = '{1'b0, addr_q, pix_rd_q[7:0], pix_rd_q[15:8],
                       pix_rd_q[23:16], pix_rd_q[31:24]};
        state_d    = ST_IDLE;
      end
      ST_LOOK: begin
        if (lk_cnt_q == LOOK_LAST) begin
          state_d = ST_MAC;
          step_d  = 5'd0;
        end else begin
          lk_cnt_d = lk_cnt_q + 3'd1;
        end
      end
      ST_MAC: begin
        if (step_q == MAC_LAST) state_d = ST_PROJ;
        else step_d = step_q + 5'd1;
      end
      ST_PROJ: state_d = ST_TEST;
      ST_TEST: begin
        res_push_o = 1'b1;
        wr_addr    = waddr_q;
        dep_wd     = 16'(z_q);
        pix_wd     = shade_px;
        if (pass) begin
          dep_we = 1'b1;
          pix_we = 1'b1;
          res_d  = '{1'b1, waddr_q, shade_px[7:0], shade_px[15:8],
                     shade_px[23:16], shade_px[31:24]};
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lk_cnt_q  <= 3'd0;
      step_q    <= 5'd0;
      mac_ctl_q <= '{valid: 1'b0, first: 1'b1, last: 1'b1, neg: 1'b0, up14: 1'b0,
                     shift: SH_NONE, dest: D_NONE};
    end else begin
      state_q   <= state_d;
      lk_cnt_q  <= lk_cnt_d;
      step_q    <= step_d;
      mac_ctl_q <= mac_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    sin_rd_q <= SIN_TAB[rom_idx];
    cos_rd_q <= COS_TAB[rom_idx];
    if (cmd_pop_o) begin
      addr_q <= cmd_i.addr;
      iu_q   <= cmd_i.u_idx;
      iv_q   <= cmd_i.v_idx;
    end
    if (state_q == ST_LOOK) begin
      case (lk_cnt_q)
        3'd1: begin cu_q <= cos_rd_q; su_q <= sin_rd_q; end
        3'd2: begin cv_q <= cos_rd_q; sv_q <= sin_rd_q; end
        3'd3: begin cp_q <= cos_rd_q; sp_q <= sin_rd_q; end
        3'd4: begin ct_q <= cos_rd_q; st_q <= sin_rd_q; end
        default: ;
      endcase
    end
    prod_q <= mac_a * mac_b;
    if (mac_ctl_q.valid) begin
      acc_q <= acc_sum;
      if (mac_ctl_q.last) begin
        case (mac_ctl_q.dest)
          D_X0:    x0_q  <= mac_res[15:0];
          D_Y0:    y0_q  <= mac_res[15:0];
          D_NX0:   nx0_q <= mac_res[15:0];
          D_NY0:   ny0_q <= mac_res[15:0];
          D_PST:   pst_q <= mac_res[29:0];
          D_PCT:   pct_q <= mac_res[29:0];
          D_CST:   cst_q <= mac_res[29:0];
          D_CCT:   cct_q <= mac_res[29:0];
          D_X:     x_q   <= mac_res[17:0];
          D_Y:     y_q   <= mac_res[17:0];
          D_Z:     z_q   <= mac_res[17:0];
          D_NX:    nx_q  <= mac_res[17:0];
          D_NY:    ny_q  <= mac_res[17:0];
          D_NZ:    nz_q  <= mac_res[17:0];
          D_L2:    l2_q  <= mac_res[17:0];
          default: ;
        endcase
      end
    end
    if (state_q == ST_PROJ) begin
      waddr_q <= waddr_c;
      inb_q   <= inb_c;
    end
  end

  // Depth store: one write port, one registered read port at the projected pixel.
  always_ff @(posedge clk_i) begin
    if (dep_we) dep_mem[wr_addr] <= dep_wd;
    dep_rd_q <= dep_mem[waddr_c];
  end

  // Pixel store: one write port, one registered read port at the queued command.
  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[wr_addr] <= pix_wd;
    pix_rd_q <= pix_mem[cmd_i.addr];
  end

endmodule

// ===== rtl/torus_point_zbuffer_shader_top.sv =====
// Top level of the torus point z-buffer shader: configuration registers,
// command front end, compute back end and result queue.
// Depends on tpz_pkg, tpz_front, tpz_back and tpz_outq.
//
// Usage. Requests enter through a queue-style port: a request is taken at a
// clock edge with push high and full low. It carries func (clear, sample,
// read), the torus angles u_step and v_step and a pixel address. Every
// request yields exactly one result, offered while empty is low and taken at
// an edge with pop high. Results leave in request order.
// A clear finishes as the back end takes it; a read waits for the registered
// pixel store read. A sample passes through the sine and cosine table reads,
// the single shared multiply-accumulate unit that walks the point, normal and
// rotation terms, then projection with the depth read and the depth test.
// Requests are carried out one at a time; the next one is already waiting in
// the two-entry request queue, and finished results wait in a two-entry
// result queue, so a stalled receiver blocks the back end only once two
// results are waiting. Reset empties both queues and the registers read zero;
// the depth and pixel stores are not cleared, so every pixel must be cleared
// by a request before it is sampled or read.
// The user must write configuration over the APB-style port only while no
// request is in progress; the block itself does not enforce this.
module torus_point_zbuffer_shader_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request side.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func_i,
  input  logic [9:0]  u_step_i,
  input  logic [9:0]  v_step_i,
  input  logic [13:0] pixel_address_i,
  // Result side.
  output logic        empty,
  input  logic        pop,
  output logic        visible_o,
  output logic [13:0] written_address_o,
  output logic [7:0]  char_first_o,
  output logic [7:0]  char_second_o,
  output logic [7:0]  char_third_o,
  output logic [7:0]  char_fourth_o
);
  import tpz_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register writes; addresses beyond the register list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_COLOR_MODE: cfg_d.color_mode     = pwdata[0];
        REG_ROT_PHI:    cfg_d.rotation_phi   = pwdata[9:0];
        REG_ROT_THETA:  cfg_d.rotation_theta = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COLOR_MODE: prdata = 32'(cfg_q.color_mode);
      REG_ROT_PHI:    prdata = 32'(cfg_q.rotation_phi);
      REG_ROT_THETA:  prdata = 32'(cfg_q.rotation_theta);
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tpz_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .func_i          (func_i),
    .u_step_i        (u_step_i),
    .v_step_i        (v_step_i),
    .pixel_address_i (pixel_address_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  tpz_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  tpz_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_out)
  );

  assign visible_o         = res_out.visible;
  assign written_address_o = res_out.addr;
  assign char_first_o      = res_out.c_first;
  assign char_second_o     = res_out.c_second;
  assign char_third_o      = res_out.c_third;
  assign char_fourth_o     = res_out.c_fourth;

  // The back end never hands a result to a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // The back end only takes a request that the front end holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("request taken from an empty request queue");

  // A visible pixel always carries a printable last character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && visible_o) |-> (char_fourth_o != 8'd0))
    else $error("visible pixel with an empty fourth character");

endmodule

// ===== dv/torus_point_zbuffer_shader_top_tb.sv =====
// Testbench of the torus point z-buffer shader top level: a self-checking
// run with a behavioral shading predictor, a queued request driver and a
// result monitor. Depends on tpz_pkg and torus_point_zbuffer_shader_top.
`timescale 1ns / 1ps

module torus_point_zbuffer_shader_top_tb;
  import tpz_pkg::*;

  // Q28 angle constants of the predictor's own sine series.
  localparam longint PiQ28     = 64'sd843314857;
  localparam longint HalfPiQ28 = 64'sd421657428;
  localparam longint TwoPiQ28  = 64'sd1686629714;
  localparam int     WatchdogLimit = 20000;
  localparam int     HoldOffCycles = 400;
  localparam int     DrainCycles   = 60;

  typedef struct packed {
    func_e       func;
    logic [9:0]  u_step;
    logic [9:0]  v_step;
    logic [13:0] addr;
  } shade_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Configuration port, driven by the stimulus process only.
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Request and result ports.
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  func_i = '0;
  logic [9:0]  u_step_i = '0, v_step_i = '0;
  logic [13:0] pixel_address_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        visible_o;
  logic [13:0] written_address_o;
  logic [7:0]  char_first_o, char_second_o, char_third_o, char_fourth_o;

  always #5 clk_i = ~clk_i;

  torus_point_zbuffer_shader_top i_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .func_i, .u_step_i, .v_step_i, .pixel_address_i,
    .empty, .pop, .visible_o, .written_address_o,
    .char_first_o, .char_second_o, .char_third_o, .char_fourth_o
  );

  // Predictor state: its own copy of the registers and both pixel stores.
  logic        mdl_color_mode = 1'b0;
  logic [9:0]  mdl_phi = '0, mdl_theta = '0;
  shortint     depth_mem [STORE_DEPTH];
  logic [31:0] char_mem [STORE_DEPTH];

  // Pixels that the stimulus has already cleared, so every later read and
  // depth test touches a defined entry.
  bit          cleared_px [STORE_DEPTH];
  int          cleared_list[$];

  shade_req_t pending_reqs[$];
  res_t       expected_pixels[$];
  bit         failed = 1'b0;

  // Idling controls, set per phase by the stimulus process.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off_req = 1'b0;
  bit  req_taken = 1'b0;

  // Round to nearest with halves away from zero.
  function automatic longint round_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  // Q14 sine of a Q28 angle in [0, 2.5 pi) by a seven-term Taylor series.
  function automatic longint q14_sine(longint ang);
    bit     negate;
    longint sq, term, acc;
    negate = 1'b0;
    if (ang >= TwoPiQ28) ang -= TwoPiQ28;
    if (ang >= PiQ28) begin
      ang -= PiQ28;
      negate = 1'b1;
    end
    if (ang > HalfPiQ28) ang = PiQ28 - ang;
    if (ang < 0) ang = 0;
    sq = (ang * ang) >>> 28;
    term = ang;
    acc = ang;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * sq) >>> 28) / ((2 * n) * (2 * n + 1));
      acc = (n % 2 == 1) ? acc - term : acc + term;
    end
    if (acc < 0) acc = 0;
    acc = (acc + 8192) >>> 14;
    if (acc > 16384) acc = 16384;
    return negate ? -acc : acc;
  endfunction

  function automatic longint step_angle(longint v, longint turn);
    longint idx;
    idx = ((v * ANGLE_STEPS + turn / 2) / turn) % ANGLE_STEPS;
    return (idx * TwoPiQ28) / ANGLE_STEPS;
  endfunction

  function automatic logic [7:0] base64_digit(int d);
    if (d < 26) return 8'(65 + d);
    if (d < 52) return 8'(97 + d - 26);
    if (d < 62) return 8'(48 + d - 52);
    return (d == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [7:0] ramp_level(int lv);
    logic [7:0] ramp [10];
    ramp = '{8'h20, 8'h2E, 8'h3A, 8'h2D, 8'h3D, 8'h2B, 8'h2A, 8'h23, 8'h25, 8'h40};
    return ramp[lv];
  endfunction

  // Screen position, depth and both lights of one sample under the
  // predictor's current registers.
  function automatic void sample_point(input shade_req_t rq, output longint xi,
                                       output longint yi, output longint z,
                                       output longint l1, output longint l2);
    longint au, av, ap, at, cu, su, cv, sv, cp, sp, ct, st;
    longint rc, x0, y0, z0, x, y, nx0, ny0, nz0, nx, ny, nz;
    au = step_angle(rq.u_step, 512);
    av = step_angle(rq.v_step, 512);
    ap = step_angle(mdl_phi, 1024);
    at = step_angle(mdl_theta, 1024);
    cu = q14_sine(au + HalfPiQ28); su = q14_sine(au);
    cv = q14_sine(av + HalfPiQ28); sv = q14_sine(av);
    cp = q14_sine(ap + HalfPiQ28); sp = q14_sine(ap);
    ct = q14_sine(at + HalfPiQ28); st = q14_sine(at);

    rc = 42 * 256 + round_shift(18 * cv, 6);
    x0 = round_shift(rc * cu, 14);
    y0 = round_shift(rc * su, 14);
    z0 = round_shift(18 * sv, 6);
    x = round_shift(x0 * ct + z0 * st, 14);
    if (!mdl_color_mode) x = x * 2;
    y = round_shift(x0 * sp * st + y0 * cp * 16384 - z0 * sp * ct, 28);
    z = round_shift(-x0 * cp * st + y0 * sp * 16384 + z0 * cp * ct, 28);

    nx0 = round_shift(cv * cu, 14);
    ny0 = round_shift(cv * su, 14);
    nz0 = sv;
    nx = round_shift(nx0 * ct + nz0 * st, 14);
    ny = round_shift(nx0 * sp * st + ny0 * cp * 16384 - nz0 * sp * ct, 28);
    nz = round_shift(-nx0 * cp * st + ny0 * sp * 16384 + nz0 * cp * ct, 28);
    l1 = 2 * (nx + ny + nz);
    if (l1 < 0) l1 = 0;
    l2 = round_shift(SQRT2_Q14 * (ny + nz), 14);
    if (l2 < 0) l2 = 0;

    // Projection truncates toward zero, as signed division does.
    xi = (x + (SCREEN_WIDTH / 2) * 256) / 256;
    yi = (y + (SCREEN_HEIGHT / 2) * 256) / 256;
  endfunction

  // Pixel that a sample lands on, or -1 when it falls off the screen.
  function automatic int sample_target(shade_req_t rq);
    longint xi, yi, z, l1, l2;
    sample_point(rq, xi, yi, z, l1, l2);
    if (xi < 0 || xi >= SCREEN_WIDTH || yi < 0 || yi >= SCREEN_HEIGHT) return -1;
    return int'(14'(yi * SCREEN_WIDTH + xi));
  endfunction

  // Works out the result of one request and updates the predictor stores.
  function automatic res_t shade_pixel(shade_req_t rq);
    res_t        r;
    longint      xi, yi, z, l1, l2, red, blue, lv;
    logic [13:0] waddr;
    logic [7:0]  fill;
    r = '0;
    case (rq.func)
      FN_CLEAR: begin
        fill = mdl_color_mode ? CH_B64_ZERO : CH_SPACE;
        depth_mem[rq.addr] = -16'sd32768;
        char_mem[rq.addr] = {4{fill}};
        r.addr = rq.addr;
        {r.c_fourth, r.c_third, r.c_second, r.c_first} = {4{fill}};
        return r;
      end
      FN_READ: begin
        r.addr = rq.addr;
        {r.c_fourth, r.c_third, r.c_second, r.c_first} = char_mem[rq.addr];
        return r;
      end
      FN_NONE: return r;
      default: ;
    endcase
    sample_point(rq, xi, yi, z, l1, l2);
    if (xi < 0 || xi >= SCREEN_WIDTH || yi < 0 || yi >= SCREEN_HEIGHT) return r;
    waddr = 14'(yi * SCREEN_WIDTH + xi);
    if (z < longint'(depth_mem[waddr])) return r;
    depth_mem[waddr] = shortint'(z);

    if (mdl_color_mode) begin
      red = (255 * l1) >>> 14;
      blue = (255 * l2) >>> 14;
      if (red > 255) red = 255;
      if (blue > 255) blue = 255;
      // Green is always zero, so the middle digits carry only red and blue.
      r.c_first = base64_digit(int'(red >> 2));
      r.c_second = base64_digit(int'((red & 3) << 4));
      r.c_third = base64_digit(int'(blue >> 6));
      r.c_fourth = base64_digit(int'(blue & 63));
    end else begin
      lv = (l2 * 10) >>> 14;
      if (lv > 9) lv = 9;
      r.c_first = ramp_level(int'(lv));
      {r.c_second, r.c_third, r.c_fourth} = {3{CH_SPACE}};
    end
    char_mem[waddr] = {r.c_fourth, r.c_third, r.c_second, r.c_first};
    r.visible = 1'b1;
    r.addr = waddr;
    return r;
  endfunction

  // Request driver: takes the next queued request at the falling edge once
  // the previous one was accepted, idling at random as the phase asks.
  always @(negedge clk_i) begin
    if (rst_ni && (!push || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        shade_req_t rq;
        rq = pending_reqs.pop_front();
        push <= 1'b1;
        func_i <= rq.func;
        u_step_i <= rq.u_step;
        v_step_i <= rq.v_step;
        pixel_address_i <= rq.addr;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Acceptance of a request: the predictor runs once per accepted request.
  always @(posedge clk_i) begin
    req_taken <= push && !full;
    if (rst_ni && push && !full) begin
      shade_req_t rq;
      rq = '{func_e'(func_i), u_step_i, v_step_i, pixel_address_i};
      expected_pixels.push_back(shade_pixel(rq));
    end
    if (rst_ni && psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_COLOR_MODE: mdl_color_mode <= pwdata[0];
        REG_ROT_PHI:    mdl_phi <= pwdata[9:0];
        REG_ROT_THETA:  mdl_theta <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Result side stalls; the one long hold-off is counted here.
  int  hold_count = 0;
  always @(negedge clk_i) begin
    if (hold_off_req && hold_count < HoldOffCycles) begin
      hold_count <= hold_count + 1;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: every accepted result is checked against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no request outstanding, address %0d", written_address_o);
        failed = 1'b1;
      end else begin
        res_t e;
        e = expected_pixels.pop_front();
        if (visible_o !== e.visible) begin
          $error("visible: expected %0d, got %0d", e.visible, visible_o);
          failed = 1'b1;
        end
        if (written_address_o !== e.addr) begin
          $error("written_address: expected %0d, got %0d", e.addr, written_address_o);
          failed = 1'b1;
        end
        if (char_first_o !== e.c_first) begin
          $error("char_first: expected %0h, got %0h", e.c_first, char_first_o);
          failed = 1'b1;
        end
        if (char_second_o !== e.c_second) begin
          $error("char_second: expected %0h, got %0h", e.c_second, char_second_o);
          failed = 1'b1;
        end
        if (char_third_o !== e.c_third) begin
          $error("char_third: expected %0h, got %0h", e.c_third, char_third_o);
          failed = 1'b1;
        end
        if (char_fourth_o !== e.c_fourth) begin
          $error("char_fourth: expected %0h, got %0h", e.c_fourth, char_fourth_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: cycles in which neither side accepts anything.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL torus_point_zbuffer_shader_top");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every request is out and every result is back, then lets
  // the back end settle.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || push || expected_pixels.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic add_req(func_e f, int u, int v, int a);
    pending_reqs.push_back('{f, 10'(u), 10'(v), 14'(a)});
    if (f == FN_CLEAR && !cleared_px[14'(a)]) begin
      cleared_px[14'(a)] = 1'b1;
      cleared_list.push_back(int'(14'(a)));
    end
  endtask

  // Queues a clear of a pixel that no request has cleared yet.
  task automatic ensure_cleared(int a);
    if (!cleared_px[14'(a)]) add_req(FN_CLEAR, 0, 0, a);
  endtask

  // A sample is preceded by a clear of the pixel it lands on when needed.
  // The target follows the registers in force when the sample is queued.
  task automatic add_sample(int u, int v, int a);
    shade_req_t rq;
    int         tgt;
    rq = '{FN_SAMPLE, 10'(u), 10'(v), 14'(a)};
    tgt = sample_target(rq);
    if (tgt >= 0) ensure_cleared(tgt);
    pending_reqs.push_back(rq);
  endtask

  task automatic add_read(int u, int v, int a);
    ensure_cleared(a);
    add_req(FN_READ, u, v, a);
  endtask

  // Random request mix: mostly samples, with reads, clears and the unused
  // command as noise. Angles stay within one turn most of the time.
  task automatic add_random_reqs(int count);
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        if ($urandom_range(4) == 0) add_sample($urandom_range(1023),
                                               $urandom_range(1023), $urandom);
        else add_sample($urandom_range(512), $urandom_range(512), $urandom);
      end else if (roll < 85) begin
        if (cleared_list.size() != 0 && $urandom_range(3) != 0)
          add_req(FN_READ, $urandom, $urandom,
                  cleared_list[$urandom_range(cleared_list.size() - 1)]);
        else add_read($urandom, $urandom, $urandom_range(16383));
      end else if (roll < 95) begin
        add_req(FN_CLEAR, $urandom, $urandom, $urandom_range(16383));
      end else begin
        add_req(FN_NONE, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int phase_cfg [6][3];
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    cfg_write(REG_COLOR_MODE, 32'd0);
    cfg_write(REG_ROT_PHI, 32'd0);
    cfg_write(REG_ROT_THETA, 32'd0);

    // Directed part: angle extremes, wrapped angles, equal depth on a
    // repeated sample, address extremes, the unused command.
    add_sample(0, 0, 0);
    add_sample(0, 0, 16383);
    add_sample(512, 512, 0);
    add_sample(256, 128, 0);
    add_sample(128, 384, 0);
    add_sample(1023, 1023, 16383);
    add_sample(600, 700, 0);
    add_sample(384, 256, 0);
    add_read(0, 0, 0);
    add_read(1023, 1023, 16383);
    add_read(0, 0, 64 * 128 + 64);
    add_req(FN_CLEAR, 1023, 1023, 16383);
    add_read(0, 0, 16383);
    add_req(FN_NONE, 1023, 1023, 16383);
    add_req(FN_NONE, 0, 0, 0);
    add_sample(64, 32, 0);
    add_sample(64, 32, 0);
    wait_idle();

    phase_cfg = '{'{1, 0, 0}, '{0, 1023, 1023}, '{1, 1023, 512}, '{0, 256, 0},
                  '{1, -1, -1}, '{0, -1, -1}};
    for (int p = 0; p < 6; p++) begin
      cfg_write(REG_COLOR_MODE, phase_cfg[p][0]);
      cfg_write(REG_ROT_PHI, phase_cfg[p][1] < 0 ? $urandom_range(1023) : phase_cfg[p][1]);
      cfg_write(REG_ROT_THETA,
                phase_cfg[p][2] < 0 ? $urandom_range(1023) : phase_cfg[p][2]);
      // Cycle through the idling styles: none, sender, receiver, both.
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // The long receiver hold-off lands in the first phase, with the sender
      // pushing at full rate so the queues fill and full rises.
      if (p == 0) hold_off_req = 1'b1;
      add_random_reqs(40);
      wait_idle();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    if (!failed) begin
      $display("PASS torus_point_zbuffer_shader_top");
    end else begin
      $display("FAIL torus_point_zbuffer_shader_top");
    end
    $finish;
  end

endmodule
